// ----- hw/rtl/mpt_pkg.sv -----
`default_nettype none

package mpt_pkg;

  // Width of the stored limit and countdown
  localparam int unsigned TimeBits = 24;
  // Fixed widths of the stream fields
  localparam int unsigned OpW = 3;
  localparam int unsigned AmtW = 25;
  localparam int unsigned FieldW = 24;
  // Width of a signed sum of a time value and an amount, with room to spare
  localparam int unsigned SumW = ((TimeBits > FieldW) ? TimeBits : FieldW) + 2;
  localparam int unsigned InDataW = 32;
  localparam int unsigned OutDataW = 56;

  // Operation codes
  localparam logic [OpW-1:0] OpTick = 3'd0;
  localparam logic [OpW-1:0] OpStart = 3'd1;
  localparam logic [OpW-1:0] OpStartNew = 3'd2;
  localparam logic [OpW-1:0] OpExpire = 3'd3;
  localparam logic [OpW-1:0] OpAdd = 3'd4;
  localparam logic [OpW-1:0] OpQuery = 3'd5;

  typedef struct packed {
    logic [OpW-1:0] opcode;
    logic signed [AmtW-1:0] amount_ms;
  } in_item_t;

  typedef struct packed {
    logic is_active;
    logic has_expired;
    logic [FieldW-1:0] remaining_ms;
    logic [FieldW-1:0] limit_ms;
  } result_t;

  // Clamp a signed sum into 0 .. 2^TimeBits-1
  function automatic logic [TimeBits-1:0] clamp_time(input logic [SumW-1:0] v);
    logic [SumW-2:0] tmax;
    logic [TimeBits-1:0] res;
    tmax = {{(SumW-1-TimeBits){1'b0}}, {TimeBits{1'b1}}};
    if (v[SumW-1]) begin
      res = '0;
    end else if (v[SumW-2:0] > tmax) begin
      res = '1;
    end else begin
      res = v[TimeBits-1:0];
    end
    return res;
  endfunction

  // Sign-extend an amount to the sum width
  function automatic logic [SumW-1:0] sext_amt(input logic [AmtW-1:0] a);
    return {{(SumW-AmtW){a[AmtW-1]}}, a};
  endfunction

  // Zero-extend a time value to the sum width
  function automatic logic [SumW-1:0] zext_time(input logic [TimeBits-1:0] t);
    return {{(SumW-TimeBits){1'b0}}, t};
  endfunction

  // Mask or extend a time value to the output field width
  function automatic logic [FieldW-1:0] to_field(input logic [TimeBits-1:0] t);
    logic [FieldW+TimeBits-1:0] ext;
    ext = {{FieldW{1'b0}}, t};
    return ext[FieldW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/millisecond_protocol_timer.sv -----
// Millisecond protocol timer.
// One operation per transaction on the slave stream: s_axis_tdata_i carries
// opcode (tick, start, start with new limit, expire now, add time, query) and
// a signed amount. Every operation returns one result on the master stream:
// active flag, expired flag, remaining count and reload limit, all taken
// after the operation is applied. Counts saturate between zero and the
// maximum count; lateness past the deadline is not kept.
// An accepted transaction is captured in the input register; the state update
// then writes the new state and its result into the result register.
// Throughput: one transaction per cycle while the receiver does not stall; the
// limit, countdown and active registers update as each result is loaded.
// Reset clears the limit, the countdown, the active flag and both pipeline
// valid bits; the timer comes up inactive with a zero limit.
// When the receiver stalls, the result register holds, the input register
// holds one more transaction behind it, and s_axis_tready_o then drops until
// the master side moves again.
`default_nettype none

module millisecond_protocol_timer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [2:0] opcode, [27:3] amount_ms, [31:28] zero
  input  wire logic [mpt_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [0] is_active, [1] has_expired, [25:2] remaining_ms, [49:26] limit_ms,
  // [55:50] zero
  output logic [mpt_pkg::OutDataW-1:0]       m_axis_tdata_o
);

  logic              adv;
  logic              item_vld;
  mpt_pkg::in_item_t item;
  logic              out_vld;
  mpt_pkg::result_t  result;

  // Move the pipeline when the result register is free or being read
  assign adv = !out_vld || m_axis_tready_i;

  mpt_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tdata_i  (s_axis_tdata_i),
    .adv_i      (adv),
    .s_tready_o (s_axis_tready_o),
    .item_vld_o (item_vld),
    .item_o     (item)
  );

  mpt_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_vld_i (item_vld),
    .item_i     (item),
    .adv_i      (adv),
    .out_vld_o  (out_vld),
    .result_o   (result)
  );

  // Pack the result fields, lowest first
  assign m_axis_tvalid_o = out_vld;
  assign m_axis_tdata_o  = {6'b0, result.limit_ms, result.remaining_ms,
                            result.has_expired, result.is_active};

endmodule

`default_nettype wire

// ----- hw/rtl/mpt_in_stage.sv -----
`default_nettype none

module mpt_in_stage (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_tvalid_i,
  input  wire logic [mpt_pkg::InDataW-1:0]  s_tdata_i,
  input  wire logic                         adv_i,
  output logic                              s_tready_o,
  output logic                              item_vld_o,
  output mpt_pkg::in_item_t                 item_o
);

  logic              vld_q;
  mpt_pkg::in_item_t item_q;

  // Take a new transaction when empty or when the held one moves on
  assign s_tready_o = !vld_q || adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_tready_o) begin
      vld_q <= s_tvalid_i;
    end
  end

  // Capture the payload fields
  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      item_q.opcode    <= s_tdata_i[mpt_pkg::OpW-1:0];
      item_q.amount_ms <= s_tdata_i[mpt_pkg::OpW+mpt_pkg::AmtW-1:mpt_pkg::OpW];
    end
  end

  assign item_vld_o = vld_q;
  assign item_o     = item_q;

endmodule

`default_nettype wire

// ----- hw/rtl/mpt_core.sv -----
`default_nettype none

module mpt_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              item_vld_i,
  input  wire mpt_pkg::in_item_t item_i,
  input  wire logic              adv_i,
  output logic                   out_vld_o,
  output mpt_pkg::result_t       result_o
);

  logic [mpt_pkg::TimeBits-1:0] limit_q, limit_d;
  logic [mpt_pkg::TimeBits-1:0] count_q, count_d;
  logic                         run_q, run_d;
  logic                         out_vld_q;
  mpt_pkg::result_t             res_q;
  logic [mpt_pkg::SumW-1:0]     amt_ext;
  logic                         take;

  assign take    = adv_i && item_vld_i;
  assign amt_ext = mpt_pkg::sext_amt(item_i.amount_ms);

  // Apply one operation to the timer state
  always_comb begin
    limit_d = limit_q;
    count_d = count_q;
    run_d   = run_q;
    case (item_i.opcode)
      mpt_pkg::OpTick: begin
        if (run_q && (count_q != '0)) begin
          count_d = count_q - mpt_pkg::TimeBits'(1);
        end
      end
      mpt_pkg::OpStart: begin
        count_d = limit_q;
        run_d   = 1'b1;
      end
      mpt_pkg::OpStartNew: begin
        limit_d = mpt_pkg::clamp_time(amt_ext);
        count_d = limit_d;
        run_d   = 1'b1;
      end
      mpt_pkg::OpExpire: begin
        count_d = '0;
        run_d   = 1'b1;
      end
      mpt_pkg::OpAdd: begin
        limit_d = mpt_pkg::clamp_time(mpt_pkg::zext_time(limit_q) + amt_ext);
        if (run_q) begin
          count_d = mpt_pkg::clamp_time(mpt_pkg::zext_time(count_q) + amt_ext);
        end
      end
      default: begin
        // query and unused codes leave the state alone
      end
    endcase
  end

  // Hold the timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= '0;
      count_q   <= '0;
      run_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_i) begin
        out_vld_q <= item_vld_i;
      end
      if (take) begin
        limit_q <= limit_d;
        count_q <= count_d;
        run_q   <= run_d;
      end
    end
  end

  // Load the result from the updated state
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q.is_active    <= run_d;
      res_q.has_expired  <= run_d && (count_d == '0);
      res_q.remaining_ms <= run_d ? mpt_pkg::to_field(count_d) : '0;
      res_q.limit_ms     <= mpt_pkg::to_field(limit_d);
    end
  end

  assign out_vld_o = out_vld_q;
  assign result_o  = res_q;

endmodule

`default_nettype wire
